### sv/scta_pkg.sv
// scta_pkg: shared types and constants for the scan code to ascii converter
// depends on nothing; imported by scta_front, scta_back and the top level
`default_nettype none

package scta_pkg;

    // keymap geometry
    localparam int MAP_DEPTH = 128;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAUSE_KEY_CODE   = 2'd0,
        CFG_PAUSE_SKIP_BYTES = 2'd1
    } t_cfg_idx;

    // input commands
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    // special scan bytes and keys
    localparam logic [7:0] BYTE_PAUSE_PREFIX = 8'hE1;
    localparam logic [7:0] BYTE_EXT_PREFIX   = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT        = 7'd42;
    localparam logic [6:0] KEY_RSHIFT        = 7'd54;
    localparam logic [6:0] KEY_CAPS          = 7'd58;
    localparam logic [6:0] KEY_NUM           = 7'd69;
    localparam logic [6:0] KEY_SCROLL        = 7'd70;
    localparam logic [6:0] KEY_SYM_LO        = 7'd2;
    localparam logic [6:0] KEY_SYM_HI        = 7'd53;
    localparam logic [6:0] KEY_PAD_LO        = 7'd71;
    localparam logic [6:0] KEY_PAD_HI        = 7'd83;
    localparam logic [7:0] CHAR_A_LOWER      = 8'h61;
    localparam logic [7:0] CHAR_Z_LOWER      = 8'h7A;

    // classified transaction from front to back, aligned with keymap read data
    typedef struct packed {
        logic       valid;
        logic       is_pause;
        logic [7:0] pause_code;
        logic [7:0] raw_byte;
        logic       pressed;
        logic       extended_key;
        logic       led_update;
        logic [2:0] led_bits;
        logic       letter_shift;
        logic       other_shift;
    } t_class;

    // finished result as held in the queue
    typedef struct packed {
        logic [7:0] key_code;
        logic [7:0] raw_byte;
        logic       pressed;
        logic       extended_key;
        logic       led_update;
        logic [2:0] led_bits;
    } t_result;

    // queue status back to the front
    typedef struct packed {
        logic [QCW-1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

### sv/scta_ram.sv
// scta_ram: generic single-port ram with registered read
// depends on nothing
`default_nettype none

module scta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/scta_front.sv
// scta_front: accepts items, keeps lock, prefix and skip state, drives keymap access
// depends on scta_pkg
`default_nettype none

module scta_front
    import scta_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [7:0]            i_scan_byte,
    input  wire logic [MAP_AW-1:0]     i_map_index,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_q_status             i_q_status,
    output logic                       o_map_we,
    output logic [MAP_AW-1:0]          o_map_addr,
    output t_class                     o_class
);

    logic [7:0] r_pause_code;
    logic [2:0] r_pause_skip;
    logic       r_shift, r_caps, r_num, r_scroll, r_prefix;
    logic [2:0] r_skip;
    t_class     r_class;

    logic       n_shift, n_caps, n_num, n_scroll, n_prefix;
    logic [2:0] n_skip;
    t_class     n_class;

    logic       accept;
    logic [6:0] key;
    logic       pressed;
    logic [QCW:0] occupancy;

    // room for one more transaction counting the one in flight
    assign occupancy  = {1'b0, i_q_status.count} + {{QCW{1'b0}}, r_class.valid};
    assign o_in_ready = (occupancy < (QCW+1)'(QDEPTH));
    assign accept     = i_in_valid && o_in_ready;

    assign key     = i_scan_byte[6:0];
    assign pressed = ~i_scan_byte[7];

    // keymap access: load writes, convert reads the key entry
    assign o_map_we   = accept && (i_command == CMD_LOAD);
    assign o_map_addr = (i_command == CMD_LOAD) ? i_map_index : key[MAP_AW-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_code <= 8'd0;
            r_pause_skip <= 3'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAUSE_KEY_CODE:   r_pause_code <= i_cfg_data;
                CFG_PAUSE_SKIP_BYTES: r_pause_skip <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // classify the byte and work out the next key state
    always_comb begin
        n_shift  = r_shift;
        n_caps   = r_caps;
        n_num    = r_num;
        n_scroll = r_scroll;
        n_prefix = r_prefix;
        n_skip   = r_skip;

        n_class              = '0;
        n_class.pause_code   = r_pause_code;
        n_class.raw_byte     = i_scan_byte;
        n_class.pressed      = pressed;
        n_class.extended_key = r_prefix;
        n_class.letter_shift = r_shift ^ r_caps;
        if ((key >= KEY_SYM_LO) && (key <= KEY_SYM_HI)) begin
            n_class.other_shift = r_shift;
        end else begin
            n_class.other_shift = (key >= KEY_PAD_LO) && (key <= KEY_PAD_HI)
                                  && !r_prefix && r_num;
        end

        if (accept && (i_command == CMD_CONVERT)) begin
            if (r_skip != 3'd0) begin
                n_skip = r_skip - 3'd1;
            end else if (i_scan_byte == BYTE_PAUSE_PREFIX) begin
                n_skip               = r_pause_skip;
                n_class.valid        = 1'b1;
                n_class.is_pause     = 1'b1;
                n_class.pressed      = 1'b1;
                n_class.extended_key = 1'b0;
            end else if (i_scan_byte == BYTE_EXT_PREFIX) begin
                n_prefix = 1'b1;
            end else begin
                n_class.valid = 1'b1;
                n_prefix      = 1'b0;
                if ((key == KEY_LSHIFT) || (key == KEY_RSHIFT)) begin
                    n_shift = pressed;
                end else if (pressed && (key == KEY_CAPS)) begin
                    n_caps             = ~r_caps;
                    n_class.led_update = 1'b1;
                end else if (pressed && (key == KEY_NUM)) begin
                    n_num              = ~r_num;
                    n_class.led_update = 1'b1;
                end else if (pressed && (key == KEY_SCROLL)) begin
                    n_scroll           = ~r_scroll;
                    n_class.led_update = 1'b1;
                end
            end
        end

        n_class.led_bits = {n_caps, n_num, n_scroll};
    end

    // key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_num    <= 1'b0;
            r_scroll <= 1'b0;
            r_prefix <= 1'b0;
            r_skip   <= 3'd0;
        end else begin
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            r_num    <= n_num;
            r_scroll <= n_scroll;
            r_prefix <= n_prefix;
            r_skip   <= n_skip;
        end
    end

    // classified transaction register, lines up with keymap read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= '0;
        end else begin
            r_class <= n_class;
        end
    end

    assign o_class = r_class;

endmodule

`default_nettype wire

### sv/scta_back.sv
// scta_back: picks plain or shifted code and queues finished results
// depends on scta_pkg
`default_nettype none

module scta_back
    import scta_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_class     i_class,
    input  wire logic [7:0] i_plain,
    input  wire logic [7:0] i_shifted,
    output t_q_status       o_q_status,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_result         o_result
);

    t_result        r_q [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;

    t_result n_result;
    logic    is_letter;
    logic    use_shift;
    logic    push, pop;

    // code selection
    assign is_letter = (i_plain >= CHAR_A_LOWER) && (i_plain <= CHAR_Z_LOWER);
    assign use_shift = is_letter ? i_class.letter_shift : i_class.other_shift;

    always_comb begin
        n_result.raw_byte     = i_class.raw_byte;
        n_result.pressed      = i_class.pressed;
        n_result.extended_key = i_class.extended_key;
        n_result.led_update   = i_class.led_update;
        n_result.led_bits     = i_class.led_bits;
        if (i_class.is_pause) begin
            n_result.key_code = i_class.pause_code;
        end else if (use_shift) begin
            n_result.key_code = i_shifted;
        end else begin
            n_result.key_code = i_plain;
        end
    end

    // result queue; the front only sends when a slot is free
    assign push = i_class.valid;
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_out_valid      = (r_count != '0);
    assign o_result         = r_q[r_rd_ptr];
    assign o_q_status.count = r_count;

endmodule

`default_nettype wire

### sv/scan_code_to_ascii_converter_top.sv
// scan_code_to_ascii_converter_top: set-1 scan byte to key code converter
// depends on scta_pkg, scta_ram, scta_front, scta_back
//
// channel  direction  handshake                  payload
// in       in         i_in_valid / o_in_ready    command, scan_byte, map_index, chars
// out      out        o_out_valid / i_out_ready  key_code, raw_byte, flags, led_bits
// cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one transaction per cycle while o_in_ready is high; a result shows on the out
// channel once its byte has passed the registered keymap read and then the queue write.
// reset is synchronous, active low; lock, prefix and skip state clear, the
// keymap holds garbage until loaded. a stalled out channel fills a four-entry
// result queue, after which o_in_ready drops; config writes are always taken.
`default_nettype none

module scan_code_to_ascii_converter_top
    import scta_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [7:0]            i_scan_byte,
    input  wire logic [MAP_AW-1:0]     i_map_index,
    input  wire logic [7:0]            i_plain_char,
    input  wire logic [7:0]            i_shifted_char,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [7:0]                 o_key_code,
    output logic [7:0]                 o_raw_byte,
    output logic                       o_pressed,
    output logic                       o_extended_key,
    output logic                       o_led_update,
    output logic [2:0]                 o_led_bits,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              map_we;
    logic [MAP_AW-1:0] map_addr;
    logic [7:0]        plain_rd, shifted_rd;
    t_class            cls;
    t_q_status         q_status;
    t_result           result;

    assign o_cfg_ready = 1'b1;

    // front: accept, classify, state
    scta_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_scan_byte(i_scan_byte),
        .i_map_index(i_map_index),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_status (q_status),
        .o_map_we   (map_we),
        .o_map_addr (map_addr),
        .o_class    (cls)
    );

    // keymaps
    scta_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_plain_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_addr (map_addr),
        .i_wdata(i_plain_char),
        .o_rdata(plain_rd)
    );

    scta_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_shifted_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_addr (map_addr),
        .i_wdata(i_shifted_char),
        .o_rdata(shifted_rd)
    );

    // back: code select and result queue
    scta_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_class    (cls),
        .i_plain    (plain_rd),
        .i_shifted  (shifted_rd),
        .o_q_status (q_status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_result   (result)
    );

    assign o_key_code     = result.key_code;
    assign o_raw_byte     = result.raw_byte;
    assign o_pressed      = result.pressed;
    assign o_extended_key = result.extended_key;
    assign o_led_update   = result.led_update;
    assign o_led_bits     = result.led_bits;

endmodule

`default_nettype wire
